// File: hw/rtl/shd_pkg.sv
package shd_pkg;

  // Sync character that opens every frame
  localparam logic [7:0] SyncChar = 8'h23;

  // Largest accepted payload length after reset
  localparam logic [31:0] DefaultMaxSize = 32'd1048576;

  // Index of the last header byte, and number of id bytes in a header
  localparam logic [2:0] HeaderLast = 3'd5;
  localparam logic [2:0] IdBytes    = 3'd2;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SYNC2   = 2'd1,
    PH_HEADER  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    EVT_PAYLOAD   = 2'd0,
    EVT_EMPTY     = 2'd1,
    EVT_MALFORMED = 2'd2,
    EVT_TOO_BIG   = 2'd3
  } event_kind_e;

  typedef struct packed {
    event_kind_e kind;
    logic [15:0] id;
    logic [7:0]  data;
    logic [31:0] length;
    logic        last;
  } result_t;

endpackage

// File: hw/rtl/sync_header_message_deframer.sv
// An accepted byte's result is registered in the output register or the skid register.
// Throughput: one byte per cycle while in_stall_o is low; the front end and the output
// register run back to back, and a one-entry skid register absorbs a result while the
// output is stalled. Input stall rises only when the skid register is full.
// Reset (rst_ni low, asynchronous): hunting for the first sync byte, no result pending,
// maximum message size back to 1048576.
module sync_header_message_deframer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output shd_pkg::event_kind_e event_kind_o,
  output logic [15:0]          message_id_o,
  output logic [7:0]           payload_byte_o,
  output logic [31:0]          message_length_o,
  output logic                 last_of_message_o
);
  import shd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] id_q, id_d;
  logic [31:0] len_q, len_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] max_q;

  result_t     res;
  logic        res_vld;
  result_t     out_q, skid_q;
  logic        out_vld_q, skid_vld_q;
  logic        in_xfer, out_xfer;

  assign in_stall_o = skid_vld_q;
  assign in_xfer    = in_valid_i && !skid_vld_q;
  assign out_xfer   = out_vld_q && !out_stall_i;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= DefaultMaxSize;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  // Decode one byte: next phase, header gathering and result
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    id_d    = id_q;
    len_d   = len_q;
    rem_d   = rem_q;
    res_vld = 1'b0;
    res     = '0;
    if (in_xfer) begin
      case (phase_q)
        PH_SYNC2: begin
          if (data_byte_i == SyncChar) begin
            phase_d = PH_HEADER;
            idx_d   = '0;
            id_d    = '0;
            len_d   = '0;
          end else begin
            phase_d  = PH_HUNT;
            res_vld  = 1'b1;
            res.kind = EVT_MALFORMED;
          end
        end
        PH_HEADER: begin
          if (idx_q < IdBytes) begin
            id_d = {id_q[7:0], data_byte_i};
          end else begin
            len_d = {len_q[23:0], data_byte_i};
          end
          idx_d = idx_q + 3'd1;
          if (idx_q == HeaderLast) begin
            idx_d = '0;
            if (len_d > max_q) begin
              phase_d    = PH_HUNT;
              res_vld    = 1'b1;
              res.kind   = EVT_TOO_BIG;
              res.id     = id_d;
              res.length = len_d;
            end else if (len_d == '0) begin
              phase_d  = PH_HUNT;
              res_vld  = 1'b1;
              res.kind = EVT_EMPTY;
              res.id   = id_d;
              res.last = 1'b1;
            end else begin
              rem_d   = len_d;
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          res_vld    = 1'b1;
          res.kind   = EVT_PAYLOAD;
          res.id     = id_q;
          res.data   = data_byte_i;
          res.length = len_q;
          res.last   = (rem_q <= 32'd1);
          if (rem_q <= 32'd1) begin
            rem_d   = '0;
            phase_d = PH_HUNT;
          end else begin
            rem_d = rem_q - 32'd1;
          end
        end
        default: begin
          phase_d = (data_byte_i == SyncChar) ? PH_SYNC2 : PH_HUNT;
        end
      endcase
    end
  end

  // Deframer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      idx_q   <= '0;
      id_q    <= '0;
      len_q   <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      id_q    <= id_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
    end
  end

  // Output register and skid register: load, drain, hold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (out_xfer) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end
      end else if (res_vld) begin
        if (out_vld_q && !out_xfer) begin
          skid_vld_q <= 1'b1;
        end else begin
          out_vld_q <= 1'b1;
        end
      end else if (out_xfer) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_xfer) begin
        out_q <= skid_q;
      end
    end else if (res_vld) begin
      if (out_vld_q && !out_xfer) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o       = out_vld_q;
  assign event_kind_o      = out_q.kind;
  assign message_id_o      = out_q.id;
  assign payload_byte_o    = out_q.data;
  assign message_length_o  = out_q.length;
  assign last_of_message_o = out_q.last;

endmodule

// File: hw/rtl/shd_checker.sv
module shd_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input shd_pkg::event_kind_e event_kind_o,
  input logic [15:0]          message_id_o,
  input logic [7:0]           payload_byte_o,
  input logic [31:0]          message_length_o,
  input logic                 last_of_message_o
);
  import shd_pkg::*;

  // Hold a stalled transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_kind_o)
      && $stable(message_id_o) && $stable(payload_byte_o)
      && $stable(message_length_o) && $stable(last_of_message_o))
    else $error("stalled result changed");

  // Malformed header carries no id, length or last mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EVT_MALFORMED |->
      message_id_o == '0 && message_length_o == '0 && payload_byte_o == '0
      && !last_of_message_o)
    else $error("malformed header result has stray fields");

  // Empty message ends the message with zero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EVT_EMPTY |->
      last_of_message_o && message_length_o == '0 && payload_byte_o == '0)
    else $error("empty message result malformed");

  // Payload bytes only follow a nonzero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EVT_PAYLOAD |-> message_length_o != '0)
    else $error("payload byte with zero length");

  // Oversize rejection never marks a last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EVT_TOO_BIG |->
      !last_of_message_o && message_length_o != '0)
    else $error("too big result malformed");

endmodule

bind sync_header_message_deframer shd_checker u_shd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .event_kind_o      (event_kind_o),
  .message_id_o      (message_id_o),
  .payload_byte_o    (payload_byte_o),
  .message_length_o  (message_length_o),
  .last_of_message_o (last_of_message_o)
);

// File: sim/tb_sync_header_message_deframer.sv
`timescale 1ns / 1ps

module tb_sync_header_message_deframer;
  import shd_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseBytes  = 180;
  localparam int unsigned SettleBound = 5000;

  // Predict the event stream of the deframer and check what comes out
  class deframe_scoreboard;
    phase_e      cur_phase;
    logic [2:0]  hdr_idx;
    logic [15:0] id_acc;
    logic [31:0] len_acc;
    logic [31:0] remaining;
    logic [31:0] size_limit;
    result_t     frame_events_q[$];
    int unsigned mismatches;

    function new();
      cur_phase  = PH_HUNT;
      hdr_idx    = '0;
      id_acc     = '0;
      len_acc    = '0;
      remaining  = '0;
      size_limit = DefaultMaxSize;
      mismatches = 0;
    endfunction

    function void set_limit(logic [31:0] v);
      size_limit = v;
    endfunction

    function int unsigned pending();
      return frame_events_q.size();
    endfunction

    function void push_event(event_kind_e kind, logic [15:0] id, logic [7:0] data,
                             logic [31:0] len, logic last);
      result_t r;
      r.kind   = kind;
      r.id     = id;
      r.data   = data;
      r.length = len;
      r.last   = last;
      frame_events_q.push_back(r);
    endfunction

    // Advance the frame state by one accepted byte
    function void note_byte(logic [7:0] b);
      case (cur_phase)
        PH_SYNC2: begin
          if (b == SyncChar) begin
            cur_phase = PH_HEADER;
            hdr_idx   = '0;
            id_acc    = '0;
            len_acc   = '0;
          end else begin
            cur_phase = PH_HUNT;
            push_event(EVT_MALFORMED, 16'h0, 8'h0, 32'h0, 1'b0);
          end
        end
        PH_HEADER: begin
          if (hdr_idx < IdBytes) id_acc = {id_acc[7:0], b};
          else len_acc = {len_acc[23:0], b};
          if (hdr_idx != HeaderLast) begin
            hdr_idx = hdr_idx + 3'd1;
          end else begin
            hdr_idx = '0;
            if (len_acc > size_limit) begin
              cur_phase = PH_HUNT;
              push_event(EVT_TOO_BIG, id_acc, 8'h0, len_acc, 1'b0);
            end else if (len_acc == 32'h0) begin
              cur_phase = PH_HUNT;
              push_event(EVT_EMPTY, id_acc, 8'h0, 32'h0, 1'b1);
            end else begin
              remaining = len_acc;
              cur_phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          push_event(EVT_PAYLOAD, id_acc, b, len_acc, remaining <= 32'd1);
          if (remaining <= 32'd1) begin
            remaining = '0;
            cur_phase = PH_HUNT;
          end else begin
            remaining = remaining - 32'd1;
          end
        end
        default: begin
          if (b == SyncChar) cur_phase = PH_SYNC2;
          else cur_phase = PH_HUNT;
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    // Compare one output transfer with the oldest expected event
    task check_result(event_kind_e kind, logic [15:0] id, logic [7:0] data,
                      logic [31:0] len, logic last);
      result_t want;
      if (frame_events_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, kind %0d", kind));
        return;
      end
      want = frame_events_q.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("event_kind %0d, want %0d", kind, want.kind));
      if (id !== want.id)
        report_mismatch($sformatf("message_id %h, want %h", id, want.id));
      if (data !== want.data)
        report_mismatch($sformatf("payload_byte %h, want %h", data, want.data));
      if (len !== want.length)
        report_mismatch($sformatf("message_length %h, want %h", len, want.length));
      if (last !== want.last)
        report_mismatch($sformatf("last_of_message %b, want %b", last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  event_kind_e out_kind;
  logic [15:0] out_id;
  logic [7:0]  out_data;
  logic [31:0] out_len;
  logic        out_last;

  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;

  deframe_scoreboard sb = new();

  sync_header_message_deframer DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (in_data),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .event_kind_o     (out_kind),
    .message_id_o     (out_id),
    .payload_byte_o   (out_data),
    .message_length_o (out_len),
    .last_of_message_o(out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Note each input transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_byte(in_data);
  end

  // Check each output transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_kind, out_id, out_data, out_len, out_last);
  end

  // Stall the output at random unless calm; hold it off for a long stretch on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles - 1;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 10);
    end
  end

  // End the run if it hangs
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[sync_header_message_deframer] ERROR");
    $finish;
  end

  // Offer one byte, idle now and then, and hold until it transfers
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 5) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame_head(input logic [15:0] id, input logic [31:0] len);
    send_byte(SyncChar);
    send_byte(SyncChar);
    send_byte(id[15:8]);
    send_byte(id[7:0]);
    send_byte(len[31:24]);
    send_byte(len[23:16]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  function automatic logic [7:0] non_sync_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == SyncChar);
    return b;
  endfunction

  // Pick a payload length: mostly short, sometimes at or over the limit
  function automatic logic [31:0] pick_length();
    logic [31:0] lim;
    logic [31:0] wide;
    int unsigned sel;
    lim  = sb.size_limit;
    sel  = $urandom_range(0, 9);
    wide = $urandom;
    if (sel == 7 && lim <= 32'd64) return lim;
    if (sel == 8 && lim != 32'hFFFF_FFFF) return lim + 32'd1;
    if (sel == 9 && wide > lim) return wide;
    return $urandom_range(0, 12);
  endfunction

  // Drop valid and wait until every expected event has come out or SettleBound runs out
  task automatic settle();
    int unsigned n;
    n = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && n < SettleBound) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_limit(v);
  endtask

  // Mostly well-formed frames with random content, some noise and bad syncs
  task automatic run_random(input int unsigned budget);
    int unsigned target;
    int unsigned sel;
    logic [31:0] len;
    target = bytes_sent + budget;
    while (bytes_sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        len = pick_length();
        send_frame_head(16'($urandom), len);
        if (len != 32'h0 && len <= sb.size_limit)
          repeat (len) send_byte(8'($urandom_range(0, 255)));
      end else if (sel < 85) begin
        repeat ($urandom_range(1, 4)) send_byte(non_sync_byte());
      end else begin
        send_byte(SyncChar);
        send_byte(non_sync_byte());
      end
    end
  endtask

  initial begin
    logic [31:0] limits [6];
    limits[0] = 32'd0;
    limits[1] = 32'hFFFF_FFFF;
    limits[2] = 32'd5;
    limits[3] = DefaultMaxSize;
    limits[4] = 32'd12;
    limits[5] = 32'd1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bad second sync, empty message, short message, oversize length
    send_byte(SyncChar);
    send_byte(8'hFF);
    send_frame_head(16'hFFFF, 32'h0);
    send_frame_head(16'h0000, 32'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame_head(16'h1234, 32'hFFFF_FFFF);
    settle();

    foreach (limits[i]) begin
      write_limit(limits[i]);
      calm = (i == 1);
      if (i == 3) hold_req = 1'b1;
      run_random(PhaseBytes);
      settle();
    end

    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected events never came out", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("[sync_header_message_deframer] OK");
    end else begin
      $display("[sync_header_message_deframer] ERROR");
    end
    $finish;
  end

endmodule
